/* hw/rtl/krct_pkg.sv */
`default_nettype none
package krct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int COUNT_BITS    = 16;
    localparam int KEY_BITS      = 64;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int OUT_CNT_W = 16;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INC   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEC   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [IDX_BITS-1:0]   t_idx;

    localparam t_count COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic capture;
        logic lookup;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_stall;
    } t_dp_status;

endpackage
`default_nettype wire

/* hw/rtl/krct_ctrl.sv */
`default_nettype none
module krct_ctrl
    import krct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_status.out_stall) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_valid;
    assign o_cmd.lookup  = (r_state == S_LOOKUP);
    assign o_cmd.exec    = (r_state == S_EXEC) && !i_status.out_stall;

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == S_LOOKUP)
        else $error("accepted transaction did not start lookup");

    a_lookup_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lookup |=> r_state == S_EXEC)
        else $error("lookup not followed by execute");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.lookup, o_cmd.exec}))
        else $error("overlapping datapath commands");

endmodule
`default_nettype wire

/* hw/rtl/krct_datapath.sv */
`default_nettype none
module krct_datapath
    import krct_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_status                o_status,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [KEY_W-1:0]     i_handle_key,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [OUT_CNT_W-1:0]      o_count_value,
    output logic [STATUS_W-1:0]       o_status_code
);

    logic [TABLE_ENTRIES-1:0] r_entry_valid;
    t_key                     r_entry_keys   [TABLE_ENTRIES];
    t_count                   r_entry_counts [TABLE_ENTRIES];

    logic [OP_W-1:0] r_op;
    t_key            r_key;

    logic   r_hit;
    t_idx   r_hit_idx;
    logic   r_free_found;
    t_idx   r_free_idx;
    t_count r_cnt;

    logic                r_out_valid;
    t_count              r_out_count;
    logic [STATUS_W-1:0] r_out_status;

    logic [TABLE_ENTRIES-1:0] w_match;
    logic                     w_hit;
    t_idx                     w_hit_idx;
    logic                     w_free_found;
    t_idx                     w_free_idx;

    always_comb begin
        w_hit        = 1'b0;
        w_hit_idx    = '0;
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_match[i] = r_entry_valid[i] && (r_entry_keys[i] == r_key);
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_BITS'(i);
            end
            if (!r_entry_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IDX_BITS'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_key <= i_handle_key[KEY_BITS-1:0];
        end
        if (i_cmd.lookup) begin
            r_hit        <= w_hit;
            r_hit_idx    <= w_hit_idx;
            r_free_found <= w_free_found;
            r_free_idx   <= w_free_idx;
            r_cnt        <= r_entry_counts[w_hit_idx];
        end
    end

    logic                n_out_valid;
    t_count              n_out_count;
    logic [STATUS_W-1:0] n_out_status;
    logic                w_wr_cnt;
    logic                w_wr_key;
    logic                w_set_valid;
    logic                w_clr_valid;
    t_idx                w_wr_idx;
    t_count              w_wr_val;

    always_comb begin
        n_out_count  = '0;
        n_out_status = ST_OK;
        w_wr_cnt     = 1'b0;
        w_wr_key     = 1'b0;
        w_set_valid  = 1'b0;
        w_clr_valid  = 1'b0;
        w_wr_idx     = r_hit_idx;
        w_wr_val     = '0;
        case (r_op)
            OP_INC: begin
                if (!r_hit) begin
                    if (!r_free_found) begin
                        n_out_status = ST_FULL;
                    end else begin
                        w_wr_idx    = r_free_idx;
                        w_wr_cnt    = 1'b1;
                        w_wr_key    = 1'b1;
                        w_set_valid = 1'b1;
                        w_wr_val    = COUNT_BITS'(1);
                        n_out_count = COUNT_BITS'(1);
                    end
                end else if (r_cnt == COUNT_MAX) begin
                    n_out_count  = r_cnt;
                    n_out_status = ST_SATURATED;
                end else begin
                    w_wr_cnt    = 1'b1;
                    w_wr_val    = r_cnt + COUNT_BITS'(1);
                    n_out_count = r_cnt + COUNT_BITS'(1);
                end
            end
            OP_DEC: begin
                if (!r_hit) begin
                    n_out_status = ST_NOT_FOUND;
                end else if (r_cnt > COUNT_BITS'(1)) begin
                    w_wr_cnt    = 1'b1;
                    w_wr_val    = r_cnt - COUNT_BITS'(1);
                    n_out_count = r_cnt - COUNT_BITS'(1);
                end else begin
                    w_wr_cnt    = 1'b1;
                    w_clr_valid = 1'b1;
                end
            end
            default: begin
                if (r_hit) n_out_count = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_wr_cnt) r_entry_counts[w_wr_idx] <= w_wr_val;
            if (w_wr_key) r_entry_keys[w_wr_idx]   <= r_key;
            r_out_count  <= n_out_count;
            r_out_status <= n_out_status;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) n_out_valid = 1'b0;
        if (i_cmd.exec)             n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cmd.exec && w_set_valid) r_entry_valid[w_wr_idx] <= 1'b1;
            if (i_cmd.exec && w_clr_valid) r_entry_valid[w_wr_idx] <= 1'b0;
        end
    end

    logic [63:0] w_out_wide;
    assign w_out_wide = 64'(r_out_count);

    assign o_status.out_stall = r_out_valid && !i_ready;
    assign o_valid            = r_out_valid;
    assign o_count_value      = w_out_wide[OUT_CNT_W-1:0];
    assign o_status_code      = r_out_status;

    a_unique_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_match) <= 1)
        else $error("key present in more than one entry");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_NOT_FOUND || r_out_status == ST_FULL)
        |-> r_out_count == '0)
        else $error("failed transaction returned nonzero count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> !(r_out_valid && !i_ready))
        else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

/* hw/rtl/keyed_reference_count_table_unit.sv */
// The controller runs a capture/match/update sequence: an accepted transaction is
// captured, matched against the table, then applied, which registers the result as valid;
// o_ready stays low until the update is done, and a stalled result holds the update step.
// Reset: synchronous active-low i_rst_n clears all entry valid bits and the output
// valid; keys and counts are not reset and are read only for valid entries.
`default_nettype none
module keyed_reference_count_table_unit
    import krct_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [KEY_W-1:0]     i_handle_key,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [OUT_CNT_W-1:0]      o_count_value,
    output logic [STATUS_W-1:0]       o_status
);

    t_dp_cmd    w_cmd;
    t_dp_status w_dp_status;

    krct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_dp_status),
        .o_cmd    (w_cmd)
    );

    krct_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_dp_status),
        .i_operation   (i_operation),
        .i_handle_key  (i_handle_key),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_count_value (o_count_value),
        .o_status_code (o_status)
    );

endmodule
`default_nettype wire
